### rtl/sixma_pkg.sv
// ----------------------------------------------------------------------------
// sixma_pkg
// Shared types and constants for the six-axis moving-average filter.
// ----------------------------------------------------------------------------
package sixma_pkg;

   // number of channels: three acceleration, three rotation rate
   localparam int AXES = 6;

   // width of one raw sample and of one average
   localparam int SAMPLE_W = 16;

   // default window length in samples
   localparam int WINDOW_DEF = 50;

   // lane order of a six-axis vector
   localparam int LANE_ACCEL_X = 0;
   localparam int LANE_ACCEL_Y = 1;
   localparam int LANE_ACCEL_Z = 2;
   localparam int LANE_GYRO_X  = 3;
   localparam int LANE_GYRO_Y  = 4;
   localparam int LANE_GYRO_Z  = 5;

   // one six-axis sample, lane i holds a two's complement value
   typedef logic [AXES-1:0][SAMPLE_W-1:0] axes_type;

endpackage

### rtl/sixma_ring.sv
// ----------------------------------------------------------------------------
// sixma_ring
// Sample ring: one entry per window slot, registered read, per-entry valid
// bits so that unwritten slots read as zero, write-to-read forwarding.
// ----------------------------------------------------------------------------
module sixma_ring #(
   parameter int WINDOW = sixma_pkg::WINDOW_DEF,
   parameter int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  sixma_pkg::axes_type wr_data,
   output sixma_pkg::axes_type rd_data
);

   sixma_pkg::axes_type mem [WINDOW];
   logic [WINDOW-1:0]   slot_vld_ff;
   sixma_pkg::axes_type rd_data_ff;
   sixma_pkg::axes_type fwd_data_ff;
   logic                rd_vld_ff;
   logic                fwd_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, with the write of the same edge forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // slot valid bits, cleared at reset so the ring reads as zero-filled
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            slot_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= slot_vld_ff[rd_addr];
            fwd_ff    <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   // read data select
   always_comb begin
      priority if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_vld_ff) begin
         rd_data = rd_data_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

### rtl/sixma_div.sv
// ----------------------------------------------------------------------------
// sixma_div
// Divides six signed window sums by the window length, truncating toward
// zero: magnitude times a reciprocal, registered, then shift and sign.
// ----------------------------------------------------------------------------
module sixma_div #(
   parameter int WINDOW = sixma_pkg::WINDOW_DEF,
   parameter int SUM_W  = sixma_pkg::SAMPLE_W + $clog2(WINDOW)
) (
   input  logic                                       clock,
   input  logic                                       en,
   input  logic [sixma_pkg::AXES-1:0][SUM_W-1:0]      sums,
   output sixma_pkg::axes_type                        quot
);

   localparam int LOG_W  = $clog2(WINDOW);
   localparam int SHIFT  = SUM_W + LOG_W;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W = SUM_W + RECIP_W;
   // ceil(2^SHIFT / WINDOW), exact for every magnitude below 2^SUM_W
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_L);

   logic [sixma_pkg::AXES-1:0][SUM_W-1:0]  mag;
   logic [sixma_pkg::AXES-1:0][PROD_W-1:0] prod_in;
   logic [sixma_pkg::AXES-1:0][PROD_W-1:0] prod_ff;
   logic [sixma_pkg::AXES-1:0]             neg_ff;

   // magnitude and reciprocal product per lane
   always_comb begin
      for (int i = 0; i < sixma_pkg::AXES; i++) begin
         mag[i]     = sums[i][SUM_W-1] ? (~sums[i] + 1'b1) : sums[i];
         prod_in[i] = PROD_W'(mag[i]) * RECIP;
      end
   end

   // product register
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         for (int i = 0; i < sixma_pkg::AXES; i++) begin
            neg_ff[i] <= sums[i][SUM_W-1];
         end
      end
   end

   // quotient magnitude and sign restore
   always_comb begin
      for (int i = 0; i < sixma_pkg::AXES; i++) begin
         quot[i] = neg_ff[i] ? (~prod_ff[i][SHIFT +: sixma_pkg::SAMPLE_W] + 1'b1)
                             : prod_ff[i][SHIFT +: sixma_pkg::SAMPLE_W];
      end
   end

endmodule

### rtl/six_axis_moving_average.sv
// ----------------------------------------------------------------------------
// six_axis_moving_average
// Boxcar moving average over the last WINDOW six-axis inertial samples.
// ----------------------------------------------------------------------------
// pipeline: an accepted item passes the ring read, running-sum update,
//   reciprocal multiply and result register before its result is valid
// throughput: one item per cycle unless rsp_ready stalls it; the ring takes one read and one write a cycle
// reset: clears the running sums, the write slot and the ring valid
//   bits, so the ring reads as zero-filled and early averages count zero slots
module six_axis_moving_average #(
   parameter int WINDOW = sixma_pkg::WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sixma_pkg::SAMPLE_W-1:0] req_accel_x,
   input  logic signed [sixma_pkg::SAMPLE_W-1:0] req_accel_y,
   input  logic signed [sixma_pkg::SAMPLE_W-1:0] req_accel_z,
   input  logic signed [sixma_pkg::SAMPLE_W-1:0] req_gyro_x,
   input  logic signed [sixma_pkg::SAMPLE_W-1:0] req_gyro_y,
   input  logic signed [sixma_pkg::SAMPLE_W-1:0] req_gyro_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sixma_pkg::SAMPLE_W-1:0] rsp_avg_accel_x,
   output logic signed [sixma_pkg::SAMPLE_W-1:0] rsp_avg_accel_y,
   output logic signed [sixma_pkg::SAMPLE_W-1:0] rsp_avg_accel_z,
   output logic signed [sixma_pkg::SAMPLE_W-1:0] rsp_avg_gyro_x,
   output logic signed [sixma_pkg::SAMPLE_W-1:0] rsp_avg_gyro_y,
   output logic signed [sixma_pkg::SAMPLE_W-1:0] rsp_avg_gyro_z
);

   localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = sixma_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);

   logic                                  en;
   logic                                  accept;
   logic [ADDR_W-1:0]                     slot_ff;
   logic [ADDR_W-1:0]                     wslot_ff;
   sixma_pkg::axes_type                   req_vec;
   sixma_pkg::axes_type                   in_ff;
   sixma_pkg::axes_type                   old_vec;
   sixma_pkg::axes_type                   quot;
   sixma_pkg::axes_type                   rsp_data_ff;
   logic [sixma_pkg::AXES-1:0][SUM_W-1:0] sum_ff;
   logic [sixma_pkg::AXES-1:0][SUM_W-1:0] sum_in;
   logic                                  s1_vld_ff;
   logic                                  s2_vld_ff;
   logic                                  s3_vld_ff;
   logic                                  rsp_vld_ff;

   // pipeline advances whenever the result register is free or being taken
   assign en        = !rsp_vld_ff || rsp_ready;
   assign req_ready = en && !reset;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_vld_ff;

   // input lanes
   always_comb begin
      req_vec[sixma_pkg::LANE_ACCEL_X] = req_accel_x;
      req_vec[sixma_pkg::LANE_ACCEL_Y] = req_accel_y;
      req_vec[sixma_pkg::LANE_ACCEL_Z] = req_accel_z;
      req_vec[sixma_pkg::LANE_GYRO_X]  = req_gyro_x;
      req_vec[sixma_pkg::LANE_GYRO_Y]  = req_gyro_y;
      req_vec[sixma_pkg::LANE_GYRO_Z]  = req_gyro_z;
   end

   // stage valids and write slot
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         slot_ff    <= '0;
      end else if (en) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         rsp_vld_ff <= s3_vld_ff;
         if (req_valid) begin
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff    <= req_vec;
         wslot_ff <= slot_ff;
      end
   end

   // sample ring: oldest sample read at accept, new sample written when the first stage advances
   sixma_ring #(
      .WINDOW (WINDOW),
      .ADDR_W (ADDR_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .wr_en   (en && s1_vld_ff),
      .wr_addr (wslot_ff),
      .wr_data (in_ff),
      .rd_data (old_vec)
   );

   // running sums: drop the oldest sample, add the new one
   always_comb begin
      for (int i = 0; i < sixma_pkg::AXES; i++) begin
         sum_in[i] = sum_ff[i]
                   - SUM_W'($signed(old_vec[i]))
                   + SUM_W'($signed(in_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (en && s1_vld_ff) begin
         sum_ff <= sum_in;
      end
   end

   // divide by the window length
   sixma_div #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_div (
      .clock (clock),
      .en    (en && s2_vld_ff),
      .sums  (sum_ff),
      .quot  (quot)
   );

   // result register
   always_ff @(posedge clock) begin
      if (en && s3_vld_ff) begin
         rsp_data_ff <= quot;
      end
   end

   assign rsp_avg_accel_x = $signed(rsp_data_ff[sixma_pkg::LANE_ACCEL_X]);
   assign rsp_avg_accel_y = $signed(rsp_data_ff[sixma_pkg::LANE_ACCEL_Y]);
   assign rsp_avg_accel_z = $signed(rsp_data_ff[sixma_pkg::LANE_ACCEL_Z]);
   assign rsp_avg_gyro_x  = $signed(rsp_data_ff[sixma_pkg::LANE_GYRO_X]);
   assign rsp_avg_gyro_y  = $signed(rsp_data_ff[sixma_pkg::LANE_GYRO_Y]);
   assign rsp_avg_gyro_z  = $signed(rsp_data_ff[sixma_pkg::LANE_GYRO_Z]);

`ifndef SYNTHESIS
   // write slot stays inside the window
   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("write slot beyond window");

   // an accepted item enters the first stage
   a_accept_s1 : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("accepted item lost before first stage");

   // reset empties the pipeline and rewinds the ring
   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && !s1_vld_ff && (slot_ff == '0))
      else $error("reset did not clear pipeline state");

   // the slot only moves when an item is accepted
   a_slot_hold : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(slot_ff))
      else $error("write slot moved without an item");
`endif

endmodule

### verif/sixma_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sixma_checker
// Watches the sample and average channels of the six-axis moving-average
// filter, keeps its own window of the last samples per lane, and compares
// every average item with the one it worked out for the matching sample.
// ----------------------------------------------------------------------------
module sixma_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  sixma_pkg::axes_type req_sample,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  sixma_pkg::axes_type rsp_avg,
   output int                  fail_count,
   output int                  averages_owed
);

   localparam int WINDOW = sixma_pkg::WINDOW_DEF;

   // lane names for mismatch lines
   string lane_names [sixma_pkg::AXES] = '{"avg_accel_x", "avg_accel_y", "avg_accel_z",
                                           "avg_gyro_x", "avg_gyro_y", "avg_gyro_z"};

   // window history, one running sum per lane, slot of the oldest sample
   sixma_pkg::axes_type history [WINDOW];
   int                  lane_sum [sixma_pkg::AXES];
   int                  oldest_slot;

   // averages still to come, oldest first
   sixma_pkg::axes_type avg_queue [$];
   int                  failures = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      failures++;
   endtask

   // replace the oldest sample, update the sums, give the window averages
   task automatic advance_window(input sixma_pkg::axes_type sample,
                                 output sixma_pkg::axes_type averages);
      int fresh;
      int gone;
      int quotient;
      for (int lane = 0; lane < sixma_pkg::AXES; lane++) begin
         fresh = $signed(sample[lane]);
         gone  = $signed(history[oldest_slot][lane]);
         lane_sum[lane] = lane_sum[lane] - gone + fresh;
         // signed int division truncates toward zero
         quotient = lane_sum[lane] / WINDOW;
         averages[lane] = quotient[sixma_pkg::SAMPLE_W-1:0];
      end
      history[oldest_slot] = sample;
      oldest_slot = (oldest_slot == WINDOW - 1) ? 0 : oldest_slot + 1;
   endtask

   // sample and compare on every rising edge
   always @(posedge clock) begin
      sixma_pkg::axes_type want;
      sixma_pkg::axes_type fresh_avg;
      if (reset) begin
         for (int slot = 0; slot < WINDOW; slot++) history[slot] = '0;
         for (int lane = 0; lane < sixma_pkg::AXES; lane++) lane_sum[lane] = 0;
         oldest_slot = 0;
         avg_queue.delete();
      end else begin
         // average item against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (avg_queue.size() == 0) begin
               report_mismatch("average item with no sample waiting");
            end else begin
               want = avg_queue.pop_front();
               for (int lane = 0; lane < sixma_pkg::AXES; lane++) begin
                  if (rsp_avg[lane] !== want[lane])
                     report_mismatch($sformatf("%s got %h expected %h",
                        lane_names[lane], rsp_avg[lane], want[lane]));
               end
            end
         end
         // accepted sample item
         if (req_valid && req_ready) begin
            advance_window(req_sample, fresh_avg);
            avg_queue.push_back(fresh_avg);
         end
      end
      fail_count    <= failures;
      averages_owed <= avg_queue.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the six-axis moving-average filter: drives directed and
// random sample items with random idling on both channels, lets the checker
// predict and compare the averages, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 16;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   sixma_pkg::axes_type req_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   sixma_pkg::axes_type rsp_avg;
   int                  fail_count;
   int                  averages_owed;
   int                  send_idle_pct = 16;
   int                  recv_idle_pct = 86;
   int                  idle_cycles = 0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   six_axis_moving_average i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_accel_x     (req_sample[sixma_pkg::LANE_ACCEL_X]),
      .req_accel_y     (req_sample[sixma_pkg::LANE_ACCEL_Y]),
      .req_accel_z     (req_sample[sixma_pkg::LANE_ACCEL_Z]),
      .req_gyro_x      (req_sample[sixma_pkg::LANE_GYRO_X]),
      .req_gyro_y      (req_sample[sixma_pkg::LANE_GYRO_Y]),
      .req_gyro_z      (req_sample[sixma_pkg::LANE_GYRO_Z]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_avg_accel_x (rsp_avg[sixma_pkg::LANE_ACCEL_X]),
      .rsp_avg_accel_y (rsp_avg[sixma_pkg::LANE_ACCEL_Y]),
      .rsp_avg_accel_z (rsp_avg[sixma_pkg::LANE_ACCEL_Z]),
      .rsp_avg_gyro_x  (rsp_avg[sixma_pkg::LANE_GYRO_X]),
      .rsp_avg_gyro_y  (rsp_avg[sixma_pkg::LANE_GYRO_Y]),
      .rsp_avg_gyro_z  (rsp_avg[sixma_pkg::LANE_GYRO_Z])
   );

   sixma_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_avg       (rsp_avg),
      .fail_count    (fail_count),
      .averages_owed (averages_owed)
   );

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic sixma_pkg::axes_type pack6(input logic [15:0] ax, ay, az,
                                                 gx, gy, gz);
      sixma_pkg::axes_type v;
      v[sixma_pkg::LANE_ACCEL_X] = ax;
      v[sixma_pkg::LANE_ACCEL_Y] = ay;
      v[sixma_pkg::LANE_ACCEL_Z] = az;
      v[sixma_pkg::LANE_GYRO_X]  = gx;
      v[sixma_pkg::LANE_GYRO_Y]  = gy;
      v[sixma_pkg::LANE_GYRO_Z]  = gz;
      return v;
   endfunction

   // present one sample item, with random idle cycles ahead of it
   task automatic send_item(input sixma_pkg::axes_type v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // random segments: full range, held extremes, small values, corner values
   task automatic run_random(input int count);
      int                  kind;
      int                  seg_len;
      int                  pick;
      sixma_pkg::axes_type held;
      sixma_pkg::axes_type v;
      logic [15:0]         corner [6];
      corner = '{16'h7FFF, 16'h8000, 16'h7FFE, 16'h8001, 16'h0000, 16'hFFFF};
      while (count > 0) begin
         pick = $urandom_range(0, 99);
         kind = (pick < 40) ? 0 : (pick < 60) ? 1 : (pick < 80) ? 2 : 3;
         seg_len = (kind == 1) ? $urandom_range(50, 70) : $urandom_range(1, 80);
         for (int lane = 0; lane < sixma_pkg::AXES; lane++)
            held[lane] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         for (int n = 0; n < seg_len && count > 0; n++) begin
            for (int lane = 0; lane < sixma_pkg::AXES; lane++) begin
               case (kind)
                  0: v[lane] = 16'($urandom());
                  1: v[lane] = held[lane];
                  2: v[lane] = 16'($urandom_range(0, 200) - 100);
                  default: v[lane] = corner[$urandom_range(0, 5)];
               endcase
            end
            send_item(v);
            count--;
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      int tail;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, bit patterns, truncation near zero, warm-up
      send_item(pack6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_item(pack6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(pack6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_item(pack6(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(pack6(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001));
      send_item(pack6(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA));
      send_item(pack6(16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF));
      send_item(pack6(16'd49, -16'sd49, 16'd50, -16'sd50, 16'd99, -16'sd100));
      send_item(pack6(-16'sd49, 16'd49, -16'sd50, 16'd50, -16'sd99, 16'd100));
      send_item(pack6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
      send_item(pack6(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(pack6(16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 16'h3333, 16'hCCCC));
      send_item(pack6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_item(pack6(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
      send_item(pack6(16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h1000, 16'hF000));
      send_item(pack6(16'h7FFE, 16'h8001, 16'h7FFE, 16'h8001, 16'h7FFE, 16'h8001));

      // random, in three idling phases
      run_random(400);
      send_idle_pct = 86;
      recv_idle_pct = 16;
      run_random(420);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(420);
      req_valid = 1'b0;

      // drain, then let the pipeline settle
      while (averages_owed != 0) @(negedge clock);
      for (tail = 0; tail < TAIL_CYCLES; tail++) @(negedge clock);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
